/* sv/gcot_pkg.sv */
package gcot_pkg;

   // Sizing defaults
   localparam int GRID_SIDE_MAX_DEF  = 64;
   localparam int SLOTS_PER_CELL_DEF = 8;
   localparam int FRACTION_BITS      = 8;

   // Field widths
   localparam int POS_W   = 24;
   localparam int ID_W    = 16;
   localparam int SIDE_RW = 7;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   // Action codes
   localparam logic [1:0] ACT_QUERY  = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_MOVE   = 2'd2;
   localparam logic [1:0] ACT_NONE   = 2'd3;

   // Status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_OUTSIDE = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;
   localparam logic [1:0] STAT_UNUSED  = 2'd3;

   // Register indexes
   localparam logic [1:0] REG_ORIGIN_X   = 2'd0;
   localparam logic [1:0] REG_ORIGIN_Z   = 2'd1;
   localparam logic [1:0] REG_GRID_WIDTH = 2'd2;
   localparam logic [1:0] REG_GRID_DEPTH = 2'd3;

   localparam logic [SIDE_RW-1:0] SIDE_RESET = 7'd64;

   typedef struct packed {
      logic [1:0]              action;
      logic signed [POS_W-1:0] from_x;
      logic signed [POS_W-1:0] from_z;
      logic signed [POS_W-1:0] to_x;
      logic signed [POS_W-1:0] to_z;
      logic [ID_W-1:0]         owner_id;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] found_owner;
      logic            owner_valid;
      logic            last;
      logic [1:0]      status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOC_T,
      ST_IDX_T,
      ST_LOC_F,
      ST_IDX_F,
      ST_CNT_RD,
      ST_CNT_USE,
      ST_SLOT_RD,
      ST_SLOT_USE,
      ST_FIN
   } state_type;

   // What the current pass over a cell's slots is for
   typedef enum logic [2:0] {
      MODE_QUERY,
      MODE_CHECK,
      MODE_REM_F,
      MODE_REM_T,
      MODE_REMOVE
   } mode_type;

endpackage

/* sv/grid_cell_occupancy_tracker_top.sv */
// Uniform grid occupancy tracker. After reset the block clears the per-cell count memory
// and holds busy high; register writes are taken during that time. A transaction is
// accepted when start is high and busy low. Busy stays high while the transaction is
// worked on and drops in the cycle that carries its final result, so the next transaction
// can be accepted at the edge that ends that cycle. Results come one per rsp_strobe pulse,
// each valid for a single cycle, with no way to stall them. All work is done through two
// single-port-read memories (cell counts and cell slots) with registered reads, and each
// slot visit takes a read state and a use state. A move first checks the target cell,
// scanning its slots only when it holds SLOTS_PER_CELL ids; then it removes the id from
// the source cell, removes it from the target cell and appends it there. A move refused
// because the target stays full changes nothing.
module grid_cell_occupancy_tracker_top #(
   parameter int GRID_SIDE_MAX  = gcot_pkg::GRID_SIDE_MAX_DEF,
   parameter int SLOTS_PER_CELL = gcot_pkg::SLOTS_PER_CELL_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // command channel
   input  logic                          start,
   output logic                          busy,
   input  gcot_pkg::req_type             req_data,
   // result channel
   output logic                          rsp_strobe,
   output gcot_pkg::rsp_type             rsp_data,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [gcot_pkg::CSR_AW-1:0]   paddr,
   input  logic [gcot_pkg::CSR_DW-1:0]   pwdata,
   output logic [gcot_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);

   localparam int CELLS      = GRID_SIDE_MAX * GRID_SIDE_MAX;
   localparam int CELL_W     = $clog2(CELLS);
   localparam int IDX_W      = $clog2(GRID_SIDE_MAX);
   localparam int SIDE_W     = $clog2(GRID_SIDE_MAX + 1);
   localparam int CNT_W      = $clog2(SLOTS_PER_CELL + 1);
   localparam int SLOT_DEPTH = CELLS * SLOTS_PER_CELL;
   localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
   localparam int POS_W      = gcot_pkg::POS_W;
   localparam int ID_W       = gcot_pkg::ID_W;

   localparam logic [CNT_W-1:0]  SLOTS_C   = CNT_W'(SLOTS_PER_CELL);
   localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);

   // Configuration registers
   logic [POS_W-1:0]            origin_x_ff, origin_x_in;
   logic [POS_W-1:0]            origin_z_ff, origin_z_in;
   logic [gcot_pkg::SIDE_RW-1:0] grid_width_ff, grid_width_in;
   logic [gcot_pkg::SIDE_RW-1:0] grid_depth_ff, grid_depth_in;

   // Control and datapath registers
   gcot_pkg::state_type  state_ff, state_in;
   gcot_pkg::mode_type   mode_ff, mode_in;
   gcot_pkg::req_type    req_ff, req_in;
   gcot_pkg::rsp_type    rsp_data_ff, rsp_data_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [CELL_W-1:0]    clr_ff, clr_in;
   logic [IDX_W-1:0]     cx_ff, cx_in;
   logic [IDX_W-1:0]     cz_ff, cz_in;
   logic                 inside_ff, inside_in;
   logic [CELL_W-1:0]    tcell_ff, tcell_in;
   logic [CELL_W-1:0]    fcell_ff, fcell_in;
   logic [CELL_W-1:0]    cur_cell_ff, cur_cell_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [CNT_W-1:0]     i_ff, i_in;
   logic [CNT_W-1:0]     k_ff, k_in;

   // Memories and their read registers
   logic [CNT_W-1:0]     count_mem [CELLS];
   logic [ID_W-1:0]      slot_mem [SLOT_DEPTH];
   logic [CNT_W-1:0]     cnt_rd_ff;
   logic [ID_W-1:0]      slot_rd_ff;

   logic                 cnt_we;
   logic [CELL_W-1:0]    cnt_wa;
   logic [CNT_W-1:0]     cnt_wd;
   logic                 slot_we;
   logic [SLOT_AW-1:0]   slot_wa;
   logic [ID_W-1:0]      slot_wd;
   logic [SLOT_AW-1:0]   slot_base;
   logic [SLOT_AW-1:0]   slot_ra;

   // Locate datapath
   logic [SIDE_W-1:0]    eff_w, eff_d;
   logic [POS_W-1:0]     pos_x, pos_z;
   logic [POS_W:0]       dx, dz;
   logic [POS_W-1:0]     cx_full, cz_full;
   logic                 inside_now;
   logic [CELL_W-1:0]    cell_idx;

   logic [CNT_W-1:0]     n_now;
   logic                 match;
   logic                 last_i;

   function automatic gcot_pkg::rsp_type make_rsp(logic [ID_W-1:0] owner, logic valid,
                                                  logic lst, logic [1:0] stat);
      gcot_pkg::rsp_type r;
      r.found_owner = owner;
      r.owner_valid = valid;
      r.last        = lst;
      r.status      = stat;
      return r;
   endfunction

   // Effective grid size, clamped to the storage limit
   assign eff_w = (32'(grid_width_ff) > 32'(GRID_SIDE_MAX)) ? SIDE_W'(GRID_SIDE_MAX)
                                                            : SIDE_W'(grid_width_ff);
   assign eff_d = (32'(grid_depth_ff) > 32'(GRID_SIDE_MAX)) ? SIDE_W'(GRID_SIDE_MAX)
                                                            : SIDE_W'(grid_depth_ff);

   // Position to floored cell coordinates
   assign pos_x = (state_ff == gcot_pkg::ST_LOC_F) ? req_ff.from_x : req_ff.to_x;
   assign pos_z = (state_ff == gcot_pkg::ST_LOC_F) ? req_ff.from_z : req_ff.to_z;
   assign dx = {pos_x[POS_W-1], pos_x} - {origin_x_ff[POS_W-1], origin_x_ff};
   assign dz = {pos_z[POS_W-1], pos_z} - {origin_z_ff[POS_W-1], origin_z_ff};
   assign cx_full = dx[POS_W-1:0] >> gcot_pkg::FRACTION_BITS;
   assign cz_full = dz[POS_W-1:0] >> gcot_pkg::FRACTION_BITS;
   assign inside_now = !dx[POS_W] && !dz[POS_W] &&
                       (32'(cx_full) < 32'(eff_w)) && (32'(cz_full) < 32'(eff_d));

   // Linear cell index from the registered coordinates
   assign cell_idx = CELL_W'(cz_ff) * CELL_W'(eff_w) + CELL_W'(cx_ff);

   // Slot addressing within the current cell
   assign slot_base = SLOT_AW'(cur_cell_ff) * SLOT_AW'(SLOTS_PER_CELL);
   assign slot_ra   = slot_base + SLOT_AW'(i_ff);

   assign n_now  = (cnt_rd_ff > SLOTS_C) ? SLOTS_C : cnt_rd_ff;
   assign match  = (slot_rd_ff == req_ff.owner_id);
   assign last_i = (i_ff == n_ff - CNT_W'(1));

   // Count memory
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem[cnt_wa] <= cnt_wd;
      end
      cnt_rd_ff <= count_mem[cur_cell_ff];
   end

   // Slot memory
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
      slot_rd_ff <= slot_mem[slot_ra];
   end

   // Register port
   assign pready = 1'b1;

   always_comb begin
      origin_x_in   = origin_x_ff;
      origin_z_in   = origin_z_ff;
      grid_width_in = grid_width_ff;
      grid_depth_in = grid_depth_ff;
      if (psel && penable && pwrite) begin
         case (paddr[3:2])
            gcot_pkg::REG_ORIGIN_X:   origin_x_in   = pwdata[POS_W-1:0];
            gcot_pkg::REG_ORIGIN_Z:   origin_z_in   = pwdata[POS_W-1:0];
            gcot_pkg::REG_GRID_WIDTH: grid_width_in = pwdata[gcot_pkg::SIDE_RW-1:0];
            gcot_pkg::REG_GRID_DEPTH: grid_depth_in = pwdata[gcot_pkg::SIDE_RW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         gcot_pkg::REG_ORIGIN_X:   prdata = gcot_pkg::CSR_DW'(origin_x_ff);
         gcot_pkg::REG_ORIGIN_Z:   prdata = gcot_pkg::CSR_DW'(origin_z_ff);
         gcot_pkg::REG_GRID_WIDTH: prdata = gcot_pkg::CSR_DW'(grid_width_ff);
         gcot_pkg::REG_GRID_DEPTH: prdata = gcot_pkg::CSR_DW'(grid_depth_ff);
         default:                  prdata = '0;
      endcase
   end

   // Sequencer: next state, memory writes and result generation
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      req_in        = req_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_strobe_in = 1'b0;
      clr_in        = clr_ff;
      cx_in         = cx_ff;
      cz_in         = cz_ff;
      inside_in     = inside_ff;
      tcell_in      = tcell_ff;
      fcell_in      = fcell_ff;
      cur_cell_in   = cur_cell_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      k_in          = k_ff;
      cnt_we        = 1'b0;
      cnt_wa        = cur_cell_ff;
      cnt_wd        = k_ff;
      slot_we       = 1'b0;
      slot_wa       = slot_base + SLOT_AW'(k_ff);
      slot_wd       = slot_rd_ff;

      case (state_ff)
         // sweep the count memory to zero after reset
         gcot_pkg::ST_CLEAR: begin
            cnt_we = 1'b1;
            cnt_wa = clr_ff;
            cnt_wd = '0;
            clr_in = clr_ff + CELL_W'(1);
            if (clr_ff == LAST_CELL) begin
               state_in = gcot_pkg::ST_IDLE;
            end
         end

         gcot_pkg::ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = gcot_pkg::ST_LOC_T;
            end
         end

         gcot_pkg::ST_LOC_T: begin
            if (req_ff.action == gcot_pkg::ACT_NONE) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = make_rsp('0, 1'b0, 1'b1, gcot_pkg::STAT_OK);
               state_in      = gcot_pkg::ST_IDLE;
            end else begin
               cx_in     = IDX_W'(cx_full);
               cz_in     = IDX_W'(cz_full);
               inside_in = inside_now;
               state_in  = gcot_pkg::ST_IDX_T;
            end
         end

         gcot_pkg::ST_IDX_T: begin
            if (!inside_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = make_rsp('0, 1'b0, 1'b1, gcot_pkg::STAT_OUTSIDE);
               state_in      = gcot_pkg::ST_IDLE;
            end else begin
               tcell_in = cell_idx;
               if (req_ff.action == gcot_pkg::ACT_MOVE) begin
                  state_in = gcot_pkg::ST_LOC_F;
               end else begin
                  cur_cell_in = cell_idx;
                  mode_in     = (req_ff.action == gcot_pkg::ACT_QUERY) ?
                                gcot_pkg::MODE_QUERY : gcot_pkg::MODE_REMOVE;
                  state_in    = gcot_pkg::ST_CNT_RD;
               end
            end
         end

         gcot_pkg::ST_LOC_F: begin
            cx_in     = IDX_W'(cx_full);
            cz_in     = IDX_W'(cz_full);
            inside_in = inside_now;
            state_in  = gcot_pkg::ST_IDX_F;
         end

         gcot_pkg::ST_IDX_F: begin
            if (!inside_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = make_rsp('0, 1'b0, 1'b1, gcot_pkg::STAT_OUTSIDE);
               state_in      = gcot_pkg::ST_IDLE;
            end else begin
               fcell_in    = cell_idx;
               cur_cell_in = tcell_ff;
               mode_in     = gcot_pkg::MODE_CHECK;
               state_in    = gcot_pkg::ST_CNT_RD;
            end
         end

         // count read for cur_cell is in flight
         gcot_pkg::ST_CNT_RD: begin
            state_in = gcot_pkg::ST_CNT_USE;
         end

         gcot_pkg::ST_CNT_USE: begin
            n_in = n_now;
            i_in = '0;
            k_in = '0;
            if (n_now == '0) begin
               if (mode_ff == gcot_pkg::MODE_QUERY) begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = make_rsp('0, 1'b0, 1'b1, gcot_pkg::STAT_OK);
                  state_in      = gcot_pkg::ST_IDLE;
               end else begin
                  state_in = gcot_pkg::ST_FIN;
               end
            end else if (mode_ff == gcot_pkg::MODE_CHECK && n_now < SLOTS_C) begin
               // room is certain, no scan needed
               state_in = gcot_pkg::ST_FIN;
            end else begin
               state_in = gcot_pkg::ST_SLOT_RD;
            end
         end

         // slot read at i is in flight
         gcot_pkg::ST_SLOT_RD: begin
            state_in = gcot_pkg::ST_SLOT_USE;
         end

         gcot_pkg::ST_SLOT_USE: begin
            i_in = i_ff + CNT_W'(1);
            if (mode_ff == gcot_pkg::MODE_QUERY) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = make_rsp(slot_rd_ff, 1'b1, last_i, gcot_pkg::STAT_OK);
               state_in      = last_i ? gcot_pkg::ST_IDLE : gcot_pkg::ST_SLOT_RD;
            end else begin
               // keep non-matching ids, compacted down to slot k
               if (!match) begin
                  k_in = k_ff + CNT_W'(1);
                  if (mode_ff != gcot_pkg::MODE_CHECK) begin
                     slot_we = 1'b1;
                  end
               end
               state_in = last_i ? gcot_pkg::ST_FIN : gcot_pkg::ST_SLOT_RD;
            end
         end

         gcot_pkg::ST_FIN: begin
            case (mode_ff)
               gcot_pkg::MODE_CHECK: begin
                  if (k_ff >= SLOTS_C) begin
                     rsp_strobe_in = 1'b1;
                     rsp_data_in   = make_rsp('0, 1'b0, 1'b1, gcot_pkg::STAT_FULL);
                     state_in      = gcot_pkg::ST_IDLE;
                  end else begin
                     cur_cell_in = fcell_ff;
                     mode_in     = gcot_pkg::MODE_REM_F;
                     state_in    = gcot_pkg::ST_CNT_RD;
                  end
               end
               gcot_pkg::MODE_REM_F: begin
                  cnt_we      = 1'b1;
                  cur_cell_in = tcell_ff;
                  mode_in     = gcot_pkg::MODE_REM_T;
                  state_in    = gcot_pkg::ST_CNT_RD;
               end
               gcot_pkg::MODE_REM_T: begin
                  // append the moved id after the compacted entries
                  cnt_we        = 1'b1;
                  cnt_wd        = k_ff + CNT_W'(1);
                  slot_we       = 1'b1;
                  slot_wd       = req_ff.owner_id;
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = make_rsp('0, 1'b0, 1'b1, gcot_pkg::STAT_OK);
                  state_in      = gcot_pkg::ST_IDLE;
               end
               gcot_pkg::MODE_REMOVE: begin
                  cnt_we        = 1'b1;
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = make_rsp('0, 1'b0, 1'b1, gcot_pkg::STAT_OK);
                  state_in      = gcot_pkg::ST_IDLE;
               end
               default: begin
                  state_in = gcot_pkg::ST_IDLE;
               end
            endcase
         end

         default: begin
            state_in = gcot_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gcot_pkg::ST_CLEAR;
         mode_ff       <= gcot_pkg::MODE_QUERY;
         rsp_strobe_ff <= 1'b0;
         clr_ff        <= '0;
         origin_x_ff   <= '0;
         origin_z_ff   <= '0;
         grid_width_ff <= gcot_pkg::SIDE_RESET;
         grid_depth_ff <= gcot_pkg::SIDE_RESET;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         rsp_strobe_ff <= rsp_strobe_in;
         clr_ff        <= clr_in;
         origin_x_ff   <= origin_x_in;
         origin_z_ff   <= origin_z_in;
         grid_width_ff <= grid_width_in;
         grid_depth_ff <= grid_depth_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
      cx_ff       <= cx_in;
      cz_ff       <= cz_in;
      inside_ff   <= inside_in;
      tcell_ff    <= tcell_in;
      fcell_ff    <= fcell_in;
      cur_cell_ff <= cur_cell_in;
      n_ff        <= n_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
   end

   assign busy       = (state_ff != gcot_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

/* sv/gcot_checker.sv */
module gcot_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input gcot_pkg::rsp_type rsp_data
);

   // an accepted transaction keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted transaction");

   // more results pending means the transaction is still in progress; the final one frees it
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |-> busy)
      else $error("non-final result while block idle");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last) |-> !busy)
      else $error("block still busy on final result");

   // a listed owner is only reported with ok status; an empty result carries no id
   a_owner_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_data.owner_valid && rsp_data.status == gcot_pkg::STAT_OK) ||
                      (!rsp_data.owner_valid && rsp_data.found_owner == '0 &&
                       rsp_data.last && rsp_data.status != gcot_pkg::STAT_UNUSED)))
      else $error("inconsistent result fields");

endmodule

bind grid_cell_occupancy_tracker_top gcot_checker u_gcot_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

/* verif/grid_cell_occupancy_tracker_top_tb.sv */
`timescale 1ns / 1ps

module grid_cell_occupancy_tracker_top_tb;

   localparam int CELLS        = gcot_pkg::GRID_SIDE_MAX_DEF * gcot_pkg::GRID_SIDE_MAX_DEF;
   localparam int SLOTS        = gcot_pkg::SLOTS_PER_CELL_DEF;
   localparam int CELL_SPAN    = 1 << gcot_pkg::FRACTION_BITS;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 100;
   localparam int MAX_PRINTS   = 100;
   localparam int POS_W        = gcot_pkg::POS_W;
   localparam int ID_W         = gcot_pkg::ID_W;
   localparam int SIDE_RW      = gcot_pkg::SIDE_RW;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   gcot_pkg::req_type             req_data;
   logic                          rsp_strobe;
   gcot_pkg::rsp_type             rsp_data;
   logic                          psel;
   logic                          penable;
   logic                          pwrite;
   logic [gcot_pkg::CSR_AW-1:0]   paddr;
   logic [gcot_pkg::CSR_DW-1:0]   pwdata;
   logic [gcot_pkg::CSR_DW-1:0]   prdata;
   logic                          pready;

   // Predicted grid contents and register copies
   int unsigned         cell_fill [CELLS];
   logic [ID_W-1:0]     cell_ids [CELLS][SLOTS];
   int                  org_x;
   int                  org_z;
   logic [SIDE_RW-1:0]  width_reg;
   logic [SIDE_RW-1:0]  depth_reg;

   gcot_pkg::rsp_type   pending_results[$];
   int                  error_count = 0;
   int                  cycle_count = 0;
   bit                  idle_on = 1'b1;

   grid_cell_occupancy_tracker_top DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("ERROR at %0t: %s", $time, what);
   endtask

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin : check_results
      gcot_pkg::rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result owner=%h valid=%b last=%b status=%0d",
                            rsp_data.found_owner, rsp_data.owner_valid, rsp_data.last,
                            rsp_data.status));
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.found_owner !== want.found_owner ||
                rsp_data.owner_valid !== want.owner_valid ||
                rsp_data.last !== want.last || rsp_data.status !== want.status)
               report_mismatch($sformatf(
                  "result owner=%h valid=%b last=%b status=%0d, want %h %b %b %0d",
                  rsp_data.found_owner, rsp_data.owner_valid, rsp_data.last, rsp_data.status,
                  want.found_owner, want.owner_valid, want.last, want.status));
         end
      end
   end

   // ---------------- grid predictor ----------------

   function automatic int eff_side(input logic [SIDE_RW-1:0] v);
      return (v > gcot_pkg::GRID_SIDE_MAX_DEF) ? gcot_pkg::GRID_SIDE_MAX_DEF : int'(v);
   endfunction

   // Position to cell index; 0 when outside the grid
   function automatic bit map_to_cell(input logic signed [POS_W-1:0] px, pz,
                                      output int cell_no);
      int dx;
      int dz;
      int cx;
      int cz;
      int w;
      int d;
      dx = px;
      dz = pz;
      dx = dx - org_x;
      dz = dz - org_z;
      w = eff_side(width_reg);
      d = eff_side(depth_reg);
      cell_no = 0;
      if (dx < 0 || dz < 0)
         return 1'b0;
      cx = dx >>> gcot_pkg::FRACTION_BITS;
      cz = dz >>> gcot_pkg::FRACTION_BITS;
      if (cx >= w || cz >= d)
         return 1'b0;
      cell_no = cz * w + cx;
      return 1'b1;
   endfunction

   function automatic int count_kept(input int cell_no, input logic [ID_W-1:0] id);
      int kept = 0;
      for (int i = 0; i < cell_fill[cell_no]; i++)
         if (cell_ids[cell_no][i] != id)
            kept++;
      return kept;
   endfunction

   // Delete every copy of id and compact the cell
   function automatic void drop_owner(input int cell_no, input logic [ID_W-1:0] id);
      int kept = 0;
      for (int i = 0; i < cell_fill[cell_no]; i++) begin
         if (cell_ids[cell_no][i] != id) begin
            cell_ids[cell_no][kept] = cell_ids[cell_no][i];
            kept++;
         end
      end
      cell_fill[cell_no] = kept;
   endfunction

   function automatic void push_result(input logic [ID_W-1:0] owner, input logic valid, last,
                                       input logic [1:0] status);
      gcot_pkg::rsp_type r;
      r.found_owner = owner;
      r.owner_valid = valid;
      r.last        = last;
      r.status      = status;
      pending_results.insert(pending_results.size(), r);
   endfunction

   // Update the grid for one accepted transaction and queue its results
   function automatic void apply_grid_command(input gcot_pkg::req_type c);
      int tcell;
      int fcell;
      int n;
      if (c.action == gcot_pkg::ACT_NONE) begin
         push_result('0, 1'b0, 1'b1, gcot_pkg::STAT_OK);
         return;
      end
      if (!map_to_cell(c.to_x, c.to_z, tcell)) begin
         push_result('0, 1'b0, 1'b1, gcot_pkg::STAT_OUTSIDE);
         return;
      end
      case (c.action)
         gcot_pkg::ACT_QUERY: begin
            n = cell_fill[tcell];
            if (n == 0)
               push_result('0, 1'b0, 1'b1, gcot_pkg::STAT_OK);
            for (int i = 0; i < n; i++)
               push_result(cell_ids[tcell][i], 1'b1, i == n - 1, gcot_pkg::STAT_OK);
         end
         gcot_pkg::ACT_REMOVE: begin
            drop_owner(tcell, c.owner_id);
            push_result('0, 1'b0, 1'b1, gcot_pkg::STAT_OK);
         end
         default: begin
            if (!map_to_cell(c.from_x, c.from_z, fcell)) begin
               push_result('0, 1'b0, 1'b1, gcot_pkg::STAT_OUTSIDE);
            end else if (count_kept(tcell, c.owner_id) >= SLOTS) begin
               push_result('0, 1'b0, 1'b1, gcot_pkg::STAT_FULL);
            end else begin
               drop_owner(fcell, c.owner_id);
               drop_owner(tcell, c.owner_id);
               cell_ids[tcell][cell_fill[tcell]] = c.owner_id;
               cell_fill[tcell]++;
               push_result('0, 1'b0, 1'b1, gcot_pkg::STAT_OK);
            end
         end
      endcase
   endfunction

   // ---------------- drivers ----------------

   // One command transaction; start stays high for a following command
   task automatic send_command(input gcot_pkg::req_type c);
      while (idle_on && $urandom_range(99) < 37) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_data <= c;
      start    <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      apply_grid_command(c);
   endtask

   // Wait until every expected result is in and the block is idle
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
   endtask

   // Setup then access phase; psel stays up so writes can run back to back
   task automatic write_reg(input logic [1:0] idx, input int value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1)
         @(posedge clock);
   endtask

   task automatic set_grid(input int ox, oz, w, d);
      wait_idle();
      write_reg(gcot_pkg::REG_ORIGIN_X, ox);
      write_reg(gcot_pkg::REG_ORIGIN_Z, oz);
      write_reg(gcot_pkg::REG_GRID_WIDTH, w);
      write_reg(gcot_pkg::REG_GRID_DEPTH, d);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      org_x     = ox;
      org_z     = oz;
      width_reg = w[SIDE_RW-1:0];
      depth_reg = d[SIDE_RW-1:0];
   endtask

   function automatic gcot_pkg::req_type make_cmd(input logic [1:0] action,
                                                  input int fx, fz, tx, tz,
                                                  input logic [ID_W-1:0] id);
      gcot_pkg::req_type c;
      c.action   = action;
      c.from_x   = POS_W'(fx);
      c.from_z   = POS_W'(fz);
      c.to_x     = POS_W'(tx);
      c.to_z     = POS_W'(tz);
      c.owner_id = id;
      return c;
   endfunction

   // Coordinate mostly in the few cells next to the origin, some just outside, some anywhere
   function automatic logic [POS_W-1:0] pick_coord(input int origin,
                                                   input logic [SIDE_RW-1:0] side);
      int s;
      int c;
      int r;
      s = eff_side(side);
      if (s == 0)
         s = 1;
      r = $urandom_range(99);
      if (r < 8)
         return POS_W'($urandom);
      if (r < 16)
         c = $urandom_range(1) ? -1 : s;
      else if (r < 70)
         c = $urandom_range((s < 3 ? s : 3) - 1);
      else
         c = $urandom_range(s - 1);
      return POS_W'(origin + c * CELL_SPAN + $urandom_range(CELL_SPAN - 1));
   endfunction

   function automatic gcot_pkg::req_type random_command();
      gcot_pkg::req_type c;
      logic [127:0]      noise;
      int                r;
      int                k;
      r = $urandom_range(99);
      if (r < 6) begin
         noise = {$urandom, $urandom, $urandom, $urandom};
         c = noise[$bits(gcot_pkg::req_type)-1:0];
         return c;
      end
      r = $urandom_range(99);
      if (r < 50)
         c.action = gcot_pkg::ACT_MOVE;
      else if (r < 78)
         c.action = gcot_pkg::ACT_QUERY;
      else if (r < 95)
         c.action = gcot_pkg::ACT_REMOVE;
      else
         c.action = gcot_pkg::ACT_NONE;
      c.from_x = pick_coord(org_x, width_reg);
      c.from_z = pick_coord(org_z, depth_reg);
      c.to_x   = pick_coord(org_x, width_reg);
      c.to_z   = pick_coord(org_z, depth_reg);
      // small id pool so cells fill up and ids get moved around
      k = $urandom_range(11);
      if ($urandom_range(99) < 5)
         c.owner_id = ID_W'($urandom);
      else
         c.owner_id = (k == 11) ? 16'hFFFF : ID_W'(k * 16'h1111);
      return c;
   endfunction

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++)
         send_command(random_command());
   endtask

   // ---------------- tests ----------------

   task automatic test_empty_cell_and_unused_action();
      send_command(make_cmd(gcot_pkg::ACT_QUERY, 0, 0, 0, 0, 16'h0000));
      send_command(make_cmd(gcot_pkg::ACT_NONE, -1, 8388607, -8388608, -1, 16'hFFFF));
      send_command(make_cmd(gcot_pkg::ACT_REMOVE, 0, 0, 1000, 2000, 16'hFFFF));
   endtask

   task automatic test_move_and_query();
      send_command(make_cmd(gcot_pkg::ACT_MOVE, 0, 0, 0, 0, 16'h0000));
      // from the far corner cell into cell 0
      send_command(make_cmd(gcot_pkg::ACT_MOVE, 16383, 16383, 0, 0, 16'hFFFF));
      send_command(make_cmd(gcot_pkg::ACT_QUERY, 0, 0, 255, 255, 16'h0000));
      // moving within a cell sends the id to the back
      send_command(make_cmd(gcot_pkg::ACT_MOVE, 0, 0, 10, 20, 16'h0000));
      send_command(make_cmd(gcot_pkg::ACT_QUERY, 0, 0, 0, 0, 16'h0000));
      send_command(make_cmd(gcot_pkg::ACT_REMOVE, 0, 0, 128, 200, 16'hFFFF));
      send_command(make_cmd(gcot_pkg::ACT_QUERY, 0, 0, 0, 255, 16'h0000));
   endtask

   task automatic test_outside_grid();
      send_command(make_cmd(gcot_pkg::ACT_QUERY, 0, 0, -1, 0, 16'h0000));
      send_command(make_cmd(gcot_pkg::ACT_QUERY, 0, 0, 0, -1, 16'h0000));
      send_command(make_cmd(gcot_pkg::ACT_QUERY, 0, 0, 16384, 0, 16'h0000));
      send_command(make_cmd(gcot_pkg::ACT_QUERY, 0, 0, 0, 16384, 16'h0000));
      send_command(make_cmd(gcot_pkg::ACT_REMOVE, 0, 0, 8388607, -8388608, 16'h0000));
      send_command(make_cmd(gcot_pkg::ACT_MOVE, -1, 0, 0, 0, 16'h0005));
      send_command(make_cmd(gcot_pkg::ACT_MOVE, 0, 0, 0, 16384, 16'h0000));
   endtask

   task automatic test_full_cell();
      for (int i = 0; i < SLOTS; i++)
         send_command(make_cmd(gcot_pkg::ACT_MOVE, 300, 300, 256 + i * 30, 511 - i * 20,
                               ID_W'(16'h0100 + i)));
      // new id into a full cell: nothing changes, source cell untouched
      send_command(make_cmd(gcot_pkg::ACT_MOVE, 0, 0, 300, 300, 16'h0200));
      // id already there: fits again after its own removal
      send_command(make_cmd(gcot_pkg::ACT_MOVE, 0, 0, 400, 400, 16'h0103));
      send_command(make_cmd(gcot_pkg::ACT_QUERY, 0, 0, 300, 300, 16'h0000));
      send_command(make_cmd(gcot_pkg::ACT_QUERY, 0, 0, 0, 0, 16'h0000));
   endtask

   task automatic test_random_full_grid();
      set_grid(0, 0, 64, 64);
      idle_on = 1'b0;
      run_random(60);
      idle_on = 1'b1;
      run_random(50);
   endtask

   task automatic test_random_small_grid();
      set_grid(-1000, 3333, 5, 3);
      run_random(90);
   endtask

   task automatic test_random_clamped_sides();
      set_grid(-8388608, -8388608, 127, 100);
      run_random(60);
   endtask

   task automatic test_random_corner_origin();
      set_grid(8388607, 8388607, 1, 1);
      run_random(25);
   endtask

   task automatic test_zero_side();
      set_grid(0, 0, 0, 7);
      run_random(8);
      set_grid(0, 0, 9, 0);
      run_random(7);
   endtask

   // ids stay put across a resize; cells are re-indexed with the new width
   task automatic test_resize_keeps_ids();
      set_grid(12345, -777, 1, 64);
      run_random(50);
      set_grid(0, 0, 64, 64);
      run_random(70);
   endtask

   initial begin
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      psel     <= 1'b0;
      penable  <= 1'b0;
      pwrite   <= 1'b0;
      paddr    <= '0;
      pwdata   <= '0;
      org_x     = 0;
      org_z     = 0;
      width_reg = gcot_pkg::SIDE_RESET;
      depth_reg = gcot_pkg::SIDE_RESET;
      foreach (cell_fill[i])
         cell_fill[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_empty_cell_and_unused_action();
      test_move_and_query();
      test_outside_grid();
      test_full_cell();
      test_random_full_grid();
      test_random_small_grid();
      test_random_clamped_sides();
      test_random_corner_origin();
      test_zero_side();
      test_resize_keeps_ids();

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("expected results never arrived");
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
